### hw/rtl/adsr_pkg.sv
// shared types, codes and defaults for the adsr envelope generator
package adsr_pkg;

  // default sizes of the internal timer and level
  localparam int TIMER_WIDTH_DEF = 24;
  localparam int LEVEL_WIDTH_DEF = 16;

  // fixed widths of the configuration registers and the port fields
  localparam int CFG_TICK_W  = 24;
  localparam int CFG_LEVEL_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int KIND_W      = 2;
  localparam int ELAPSED_W   = 8;
  localparam int OUT_LEVEL_W = 16;
  localparam int PHASE_W     = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_TICKS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_TICKS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUSTAIN_LEVEL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_TICKS = 2'd3;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd2;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ELAPSED_W-1:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [OUT_LEVEL_W-1:0] level;
    logic [PHASE_W-1:0]     phase;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic div_init;
    logic div_step;
    logic commit;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

### hw/rtl/adsr_ctrl.sv
// sequencing state machine of the adsr envelope generator
module adsr_ctrl import adsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = status.need_div ? ST_MUL : ST_OUT;
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_OUT;
      ST_OUT: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready  = 1'b1;
        cmd.capture = item_valid;
      end
      ST_EVAL: cmd.eval     = 1'b1;
      ST_MUL:  cmd.div_init = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.commit   = 1'b1;
      ST_OUT:  cmd.load_out = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

### hw/rtl/adsr_dp.sv
// envelope state, configuration, multiplier, restoring divider and result register
module adsr_dp import adsr_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  item_t                  item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_TICK_W-1:0]  cfg_data,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result
);

  localparam int TW     = TIMER_WIDTH;
  localparam int LW     = LEVEL_WIDTH;
  localparam int DW     = CFG_TICK_W;
  localparam int CMP_W  = (TW > DW) ? TW : DW;
  localparam int SCMP_W = (LW > CFG_LEVEL_W) ? LW : CFG_LEVEL_W;
  localparam int NUM_W  = DW + LW;
  localparam int CNT_W  = $clog2(LW);
  localparam logic [TW-1:0] TIMER_MAX = {TW{1'b1}};
  localparam logic [LW-1:0] FS        = {LW{1'b1}};

  // configuration
  logic [DW-1:0]          attack_ticks;
  logic [DW-1:0]          decay_ticks;
  logic [DW-1:0]          release_ticks;
  logic [CFG_LEVEL_W-1:0] sustain_cfg;

  // envelope state
  phase_t        phase;
  logic [TW-1:0] timer;
  logic [LW-1:0] level;
  logic [LW-1:0] release_start;
  item_t         item_q;

  // divider
  logic [DW-1:0]    rem;
  logic [LW-1:0]    quot;
  logic [DW-1:0]    divisor;
  logic [CNT_W-1:0] cnt;

  logic [LW-1:0]    sustain;
  logic [TW:0]      timer_sum;
  logic [TW-1:0]    timer_new;
  logic [DW-1:0]    cur_ticks;
  logic             ticks_zero;
  logic             reached;
  logic             ramp_phase;
  logic [DW-1:0]    mul_a;
  logic [LW-1:0]    mul_b;
  logic [NUM_W-1:0] product;
  logic [DW:0]      rem_shift;
  logic [DW:0]      rem_diff;
  logic             q_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= '0;
      decay_ticks   <= '0;
      sustain_cfg   <= '1;
      release_ticks <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ATTACK_TICKS:  attack_ticks  <= cfg_data;
        CFG_DECAY_TICKS:   decay_ticks   <= cfg_data;
        CFG_SUSTAIN_LEVEL: sustain_cfg   <= cfg_data[CFG_LEVEL_W-1:0];
        CFG_RELEASE_TICKS: release_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // sustain above full scale acts as full scale
  always_comb begin
    if (SCMP_W'(sustain_cfg) > SCMP_W'(FS)) begin
      sustain = FS;
    end else begin
      sustain = LW'(sustain_cfg);
    end
  end

  // saturating timer advance
  always_comb begin
    timer_sum = {1'b0, timer} + (TW + 1)'(item_q.elapsed);
    timer_new = timer_sum[TW] ? TIMER_MAX : timer_sum[TW-1:0];
  end

  always_comb begin
    case (phase)
      PH_ATTACK:  cur_ticks = attack_ticks;
      PH_DECAY:   cur_ticks = decay_ticks;
      PH_RELEASE: cur_ticks = release_ticks;
      default:    cur_ticks = '0;
    endcase
  end

  assign ticks_zero = (cur_ticks == '0);
  assign reached    = (CMP_W'(timer_new) >= CMP_W'(cur_ticks));
  assign ramp_phase = (phase == PH_ATTACK) || (phase == PH_DECAY) || (phase == PH_RELEASE);

  assign status.need_div = (item_q.kind == KIND_TICK) && ramp_phase && !ticks_zero && !reached;

  // timer is below the duration here, so it fits the tick width
  always_comb begin
    case (phase)
      PH_ATTACK: begin
        mul_a = DW'(timer);
        mul_b = FS;
      end
      PH_DECAY: begin
        mul_a = DW'(timer);
        mul_b = FS - sustain;
      end
      PH_RELEASE: begin
        mul_a = cur_ticks - DW'(timer);
        mul_b = release_start;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = NUM_W'(mul_a) * NUM_W'(mul_b);

  // one restoring step per cycle
  assign rem_shift = {rem, quot[LW-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign q_bit     = !rem_diff[DW];

  assign status.div_last = (cnt == CNT_W'(LW - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= product[NUM_W-1:LW];
      quot    <= product[LW-1:0];
      divisor <= cur_ticks;
      cnt     <= '0;
    end else if (cmd.div_step) begin
      rem  <= q_bit ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
      quot <= {quot[LW-2:0], q_bit};
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_q <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      timer         <= '0;
      level         <= '0;
      release_start <= '0;
    end else if (cmd.eval) begin
      case (item_q.kind)
        KIND_TICK: begin
          timer <= timer_new;
          case (phase)
            PH_ATTACK: begin
              if (ticks_zero || reached) begin
                phase <= PH_DECAY;
                level <= FS;
                timer <= '0;
              end
            end
            PH_DECAY: begin
              if (ticks_zero || reached) begin
                phase <= PH_SUSTAIN;
                level <= sustain;
                timer <= '0;
              end
            end
            PH_SUSTAIN: level <= sustain;
            PH_RELEASE: begin
              if (ticks_zero || reached) begin
                phase <= PH_IDLE;
                level <= '0;
                timer <= '0;
              end
            end
            default: level <= '0;
          endcase
        end
        KIND_NOTE_ON: begin
          phase <= PH_ATTACK;
          timer <= '0;
        end
        KIND_NOTE_OFF: begin
          if (phase != PH_IDLE) begin
            release_start <= level;
            phase         <= PH_RELEASE;
            timer         <= '0;
          end
        end
        default: ;
      endcase
    end else if (cmd.commit) begin
      // decay counts down from full scale
      level <= (phase == PH_DECAY) ? FS - quot : quot;
    end
  end

  assign status.out_busy = result_valid && !result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.level <= OUT_LEVEL_W'(level);
      result.phase <= PHASE_W'(phase);
    end
  end

endmodule

### hw/rtl/adsr_envelope_generator.sv
// top level of the linear adsr envelope generator
//
// item channel (item_valid/item_ready/item): one transfer per event, a tick
// carrying elapsed ticks, a note on or a note off
// result channel (result_valid/result_ready/result): exactly one transfer per
// item, the envelope level and phase after that item
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
// always ready; write only while no item is in flight
// one item at a time; a note on, note off, unused kind or a tick that ends or
// holds a phase goes from evaluation straight to the result load
// a tick inside an attack, decay or release ramp runs the multiply and a
// restoring divider that yields one quotient bit per cycle, then commits the
// new level before the result load
// the next item is taken in the idle state that follows the result register
// load, so the work on two items never overlaps
// rst clears the phase to idle, timer, level and release start to zero and
// the registers to their defaults (sustain at full scale)
// while result_ready is low the result register holds its transfer; a new
// item is still taken and worked, and waits only for the final result load
module adsr_envelope_generator import adsr_pkg::*; #(
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input events
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  // envelope results
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_TICK_W-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: accept, evaluate, multiply, divide, commit, hand off
  adsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // envelope state, arithmetic and the result register
  adsr_dp #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### test/adsr_envelope_checker.sv
// checker for the adsr envelope generator: mirrors the envelope and compares every result
module adsr_envelope_checker import adsr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  item_t                  item,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  result_t                result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_TICK_W-1:0]  cfg_data,
  output int                     env_due,
  output int                     env_checked,
  output int                     mismatch_count
);

  localparam logic [63:0] TIMER_MAX  = (64'd1 << TIMER_WIDTH_DEF) - 64'd1;
  localparam logic [63:0] FULL_SCALE = (64'd1 << LEVEL_WIDTH_DEF) - 64'd1;

  // register copies
  logic [CFG_TICK_W-1:0]      attack_len;
  logic [CFG_TICK_W-1:0]      decay_len;
  logic [CFG_LEVEL_W-1:0]     sustain_lvl;
  logic [CFG_TICK_W-1:0]      release_len;

  // envelope state
  phase_t                     env_phase;
  logic [TIMER_WIDTH_DEF-1:0] env_timer;
  logic [OUT_LEVEL_W-1:0]     env_level;
  logic [OUT_LEVEL_W-1:0]     release_from;

  result_t expected_env[$];
  int      checked_cnt;
  int      error_cnt;

  function automatic void enter_phase(input phase_t ph, input logic [63:0] lvl);
    env_phase = ph;
    env_level = lvl[OUT_LEVEL_W-1:0];
    env_timer = '0;
  endfunction

  function automatic result_t advance_envelope(input item_t ev);
    logic [63:0] t;
    logic [63:0] dur;
    logic [63:0] sus;
    logic [63:0] q;
    result_t     r;
    sus = 64'(sustain_lvl);
    if (ev.kind == KIND_TICK) begin
      t = 64'(env_timer);
      t = t + 64'(ev.elapsed);
      if (t > TIMER_MAX) t = TIMER_MAX;
      env_timer = t[TIMER_WIDTH_DEF-1:0];
      case (env_phase)
        PH_ATTACK: begin
          dur = 64'(attack_len);
          if (dur == 0 || t >= dur) begin
            enter_phase(PH_DECAY, FULL_SCALE);
          end else begin
            q = (t * FULL_SCALE) / dur;
            env_level = q[OUT_LEVEL_W-1:0];
          end
        end
        PH_DECAY: begin
          dur = 64'(decay_len);
          if (dur == 0 || t >= dur) begin
            enter_phase(PH_SUSTAIN, sus);
          end else begin
            q = FULL_SCALE - (t * (FULL_SCALE - sus)) / dur;
            env_level = q[OUT_LEVEL_W-1:0];
          end
        end
        PH_SUSTAIN: env_level = sustain_lvl;
        PH_RELEASE: begin
          dur = 64'(release_len);
          if (dur == 0 || t >= dur) begin
            enter_phase(PH_IDLE, 64'd0);
          end else begin
            q = 64'(release_from);
            q = (q * (dur - t)) / dur;
            env_level = q[OUT_LEVEL_W-1:0];
          end
        end
        default: env_level = '0;
      endcase
    end else if (ev.kind == KIND_NOTE_ON) begin
      env_phase = PH_ATTACK;
      env_timer = '0;
    end else if (ev.kind == KIND_NOTE_OFF && env_phase != PH_IDLE) begin
      release_from = env_level;
      env_phase    = PH_RELEASE;
      env_timer    = '0;
    end
    r.level = env_level;
    r.phase = env_phase;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      attack_len   = '0;
      decay_len    = '0;
      sustain_lvl  = '1;
      release_len  = '0;
      env_phase    = PH_IDLE;
      env_timer    = '0;
      env_level    = '0;
      release_from = '0;
      expected_env.delete();
      checked_cnt  = 0;
      error_cnt    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ATTACK_TICKS:  attack_len  = cfg_data;
          CFG_DECAY_TICKS:   decay_len   = cfg_data;
          CFG_SUSTAIN_LEVEL: sustain_lvl = cfg_data[CFG_LEVEL_W-1:0];
          CFG_RELEASE_TICKS: release_len = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (expected_env.size() == 0) begin
          $error("unexpected result transfer: level %0d phase %0d", result.level, result.phase);
          error_cnt++;
        end else begin
          want = expected_env.pop_front();
          checked_cnt++;
          if (result.level !== want.level) begin
            $error("level mismatch: expected %0d, actual %0d", want.level, result.level);
            error_cnt++;
          end
          if (result.phase !== want.phase) begin
            $error("phase mismatch: expected %0d, actual %0d", want.phase, result.phase);
            error_cnt++;
          end
        end
      end
      if (item_valid && item_ready) expected_env.push_back(advance_envelope(item));
    end
    env_due        <= expected_env.size();
    env_checked    <= checked_cnt;
    mismatch_count <= error_cnt;
  end

endmodule

### test/tb.sv
// testbench top for the adsr envelope generator: stimulus, flow control and verdict
module tb;
  import adsr_pkg::*;

  // the only kind code the package leaves unnamed, ignored by the block
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int ITEM_TARGET = 1400;  // total events offered
  localparam int PER_SETTING = 160;   // events per register setting
  localparam int CALM_ITEMS  = 120;   // tail of the run with no idling
  localparam int HOLD_AFTER  = 300;   // results seen before the long back-pressure
  localparam int HOLD_CYCLES = 300;   // length of the long back-pressure
  localparam int QUIET_LIMIT = 5000;  // cycles without any transfer before giving up
  localparam int DRAIN_WAIT  = 40;    // beyond the longest ramp latency of the block

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  item_t                  item;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_TICK_W-1:0]  cfg_data;

  int env_due;
  int env_checked;
  int mismatch_count;
  int quiet_cycles;
  int items_sent;
  bit calm;
  bit long_hold_done;

  adsr_envelope_generator i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  adsr_envelope_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .env_due        (env_due),
    .env_checked    (env_checked),
    .mismatch_count (mismatch_count)
  );

  // 8 unit clock period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // count cycles in which no transfer happens on any channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: a hung block ends the run here
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // result side: random stall bursts, one long hold-off so the block backs up
  // into the event channel, and a steady ready during the calm tail
  initial begin : sink
    int burst;
    result_ready = 1'b0;
    long_hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    result_ready <= 1'b1;
    forever begin
      @(negedge clk);
      if (!long_hold_done && env_checked >= HOLD_AFTER) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        result_ready <= 1'b1;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 7);
        result_ready <= 1'b0;
        repeat (burst) @(negedge clk);
        result_ready <= 1'b1;
      end
    end
  end

  // one event transfer; an optional random gap before it drops valid for a while
  task automatic offer_event(input logic [KIND_W-1:0] kind, input logic [ELAPSED_W-1:0] ticks);
    int gap;
    item_t ev;
    ev.kind    = kind;
    ev.elapsed = ticks;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= ev;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  // drop valid and wait until every expected result has come back
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (env_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_TICK_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic shape_envelope(input logic [CFG_TICK_W-1:0] atk, input logic [CFG_TICK_W-1:0] dec,
                                input logic [CFG_LEVEL_W-1:0] sus, input logic [CFG_TICK_W-1:0] rel);
    write_reg(CFG_ATTACK_TICKS, atk);
    write_reg(CFG_DECAY_TICKS, dec);
    write_reg(CFG_SUSTAIN_LEVEL, {{(CFG_TICK_W-CFG_LEVEL_W){1'b0}}, sus});
    write_reg(CFG_RELEASE_TICKS, rel);
  endtask

  // durations lean to sizes that finish within a note, with instant and huge ones mixed in
  function automatic logic [CFG_TICK_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_TICK_W'(1);
      2:       return '1;
      3, 4, 5: return CFG_TICK_W'($urandom_range(2, 64));
      6, 7, 8: return CFG_TICK_W'($urandom_range(65, 3000));
      default: return CFG_TICK_W'($urandom_range(3001, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [CFG_LEVEL_W-1:0] pick_sustain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CFG_LEVEL_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return ELAPSED_W'($urandom_range(1, 8));
      default: return ELAPSED_W'($urandom_range(0, 255));
    endcase
  endfunction

  // a well-formed note: key down, some ticks, key up, ticks through the release
  task automatic play_note();
    int n_hold;
    int n_tail;
    n_hold = $urandom_range(1, 30);
    n_tail = $urandom_range(0, 12);
    offer_event(KIND_NOTE_ON, ELAPSED_W'($urandom_range(0, 255)));
    repeat (n_hold) offer_event(KIND_TICK, pick_elapsed());
    offer_event(KIND_NOTE_OFF, ELAPSED_W'($urandom_range(0, 255)));
    repeat (n_tail) offer_event(KIND_TICK, pick_elapsed());
  endtask

  // noise: any kind in any order, the unused code included
  task automatic scramble();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) offer_event(KIND_W'($urandom_range(0, 3)), ELAPSED_W'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int setting;
    int setting_start;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_ATTACK_TICKS;
    cfg_data   = '0;
    items_sent = 0;
    calm       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: every duration instant, sustain at full scale
    offer_event(KIND_TICK, 8'd0);        // idle tick
    offer_event(KIND_NOTE_OFF, 8'd0);    // note off in idle is ignored
    offer_event(KIND_UNUSED, 8'hFF);     // unused kind is ignored
    offer_event(KIND_TICK, 8'hFF);
    offer_event(KIND_NOTE_ON, 8'hAA);
    offer_event(KIND_UNUSED, 8'h55);
    offer_event(KIND_TICK, 8'd0);        // instant attack
    offer_event(KIND_TICK, 8'd1);        // instant decay
    offer_event(KIND_TICK, 8'hFF);       // sustain holds
    offer_event(KIND_NOTE_OFF, 8'd0);
    offer_event(KIND_TICK, 8'd0);        // instant release back to idle

    // short ramps
    settle();
    shape_envelope(24'd100, 24'd50, 16'h1234, 24'd200);
    offer_event(KIND_NOTE_ON, 8'd0);
    offer_event(KIND_TICK, 8'd1);
    offer_event(KIND_TICK, 8'd40);
    offer_event(KIND_NOTE_ON, 8'd0);     // retrigger mid-attack, level holds
    offer_event(KIND_TICK, 8'd99);
    offer_event(KIND_TICK, 8'd1);        // attack reaches its end exactly
    offer_event(KIND_TICK, 8'd25);       // mid-decay
    offer_event(KIND_NOTE_OFF, 8'd0);    // release from the decay level
    offer_event(KIND_TICK, 8'd100);
    offer_event(KIND_NOTE_OFF, 8'd0);    // note off during release restarts it
    offer_event(KIND_NOTE_ON, 8'd0);     // note on during release
    offer_event(KIND_TICK, 8'hFF);       // overshoot ends the attack

    // random notes over a series of register settings, the extremes first
    setting = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      if (setting == 0) begin
        shape_envelope('1, '1, '0, '1);
      end else if (setting == 1) begin
        shape_envelope('0, '0, '0, '0);
      end else begin
        shape_envelope(pick_duration(), pick_duration(), pick_sustain(), pick_duration());
      end
      setting++;
      setting_start = items_sent;
      while (items_sent - setting_start < PER_SETTING && items_sent < ITEM_TARGET) begin
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          scramble();
        end else begin
          play_note();
        end
      end
    end

    // drain, then give the block time to show any stray result
    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_ctrl.sv
hw/rtl/adsr_dp.sv
hw/rtl/adsr_envelope_generator.sv
test/adsr_envelope_checker.sv
test/tb.sv
